### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the sorter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KSS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define KSS_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// shared types and constants of the nearly sorted stream sorter
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int VALUE_W        = 32;
  localparam int WIN_W          = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;
  localparam int WINDOW_MAX_DEF = 16;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } kss_state_e;

  typedef struct packed {
    logic idle;
    logic draining;
  } kss_status_t;

endpackage

### hdl/kss_in_if.sv
// ----------------------------------------------------------------------------
// kss_in_if
// input sample channel: value and end-of-sequence mark
// ----------------------------------------------------------------------------
interface kss_in_if import kss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic               end_of_sequence;

  modport source (output valid, output sample_value, output end_of_sequence, input ready);
  modport sink   (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

### hdl/kss_out_if.sv
// ----------------------------------------------------------------------------
// kss_out_if
// result channel: sorted value and final mark
// ----------------------------------------------------------------------------
interface kss_out_if import kss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               final_flag;

  modport source (output valid, output sorted_value, output final_flag, input ready);
  modport sink   (input valid, input sorted_value, input final_flag, output ready);
endinterface

### hdl/kss_cfg_if.sv
// ----------------------------------------------------------------------------
// kss_cfg_if
// configuration write channel for the window size register
// ----------------------------------------------------------------------------
interface kss_cfg_if import kss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

### hdl/kss_cmd_fifo.sv
// ----------------------------------------------------------------------------
// kss_cmd_fifo
// short command queue decoupling the front end from the sorting back end
// ----------------------------------------------------------------------------
module kss_cmd_fifo import kss_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0]      mem_q [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_AW:0]   fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != (CMD_AW+1)'(CMD_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/kss_front.sv
// ----------------------------------------------------------------------------
// kss_front
// takes samples and window writes, tags each sample with its keep count
// ----------------------------------------------------------------------------
module kss_front import kss_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kss_in_if.sink                     src_i,
  kss_cfg_if.sink                    cfg_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output logic [CNT_W+VALUE_W:0]     cmd_data_o
);

  logic [WIN_W-1:0] win_q;
  logic [CNT_W-1:0] eff_win;
  logic [CNT_W-1:0] keep;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_i.valid) begin
      win_q <= cfg_i.window_size;
    end
  end

  // zero acts as one, anything above the store size is clamped
  always_comb begin
    if (win_q == '0) begin
      eff_win = CNT_W'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      eff_win = CNT_W'(WINDOW_MAX);
    end else begin
      eff_win = CNT_W'(win_q);
    end
  end

  // entries left in the heap once this item is done
  assign keep = src_i.end_of_sequence ? '0 : eff_win - 1'b1;

  assign cmd_valid_o = src_i.valid;
  assign src_i.ready = cmd_ready_i;
  assign cmd_data_o  = {keep, src_i.end_of_sequence, src_i.sample_value};

endmodule

### hdl/kss_back.sv
// ----------------------------------------------------------------------------
// kss_back
// sorted register store: one insert per command, then pops down to keep count
// ----------------------------------------------------------------------------
module kss_back import kss_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  logic [CNT_W+VALUE_W:0] cmd_data_i,
  kss_out_if.source              res_o,
  output logic [CNT_W-1:0]       count_o,
  output kss_status_t            status_o
);

  kss_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   keep_q;
  logic               last_q;
  logic [VALUE_W-1:0] ent_q [WINDOW_MAX];
  logic [VALUE_W-1:0] ent_d [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] gt;

  logic               out_vld_q;
  logic [VALUE_W-1:0] out_val_q;
  logic               out_fin_q;

  logic [VALUE_W-1:0] cmd_value;
  logic               cmd_last;
  logic [CNT_W-1:0]   cmd_keep;
  logic               slot_free;
  logic               ins, pop, above_keep;

  assign cmd_value = cmd_data_i[VALUE_W-1:0];
  assign cmd_last  = cmd_data_i[VALUE_W];
  assign cmd_keep  = cmd_data_i[CNT_W+VALUE_W:VALUE_W+1];

  assign slot_free  = !out_vld_q || res_o.ready;
  assign above_keep = (cnt_q > keep_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!above_keep || (pop && (cnt_q - 1'b1 == keep_q))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    ins         = 1'b0;
    pop         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        ins         = cmd_valid_i;
      end
      ST_DRAIN: begin
        pop = above_keep && slot_free;
      end
      default: ;
    endcase
  end

  // store stays ascending; empty slots count as larger than anything
  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_ent
    logic [VALUE_W-1:0] ins_val;
    logic [VALUE_W-1:0] pop_val;

    assign gt[g] = (CNT_W'(g) < cnt_q) ? ($signed(cmd_value) < $signed(ent_q[g])) : 1'b1;

    if (g == 0) begin : g_first
      assign ins_val = gt[g] ? cmd_value : ent_q[g];
    end else begin : g_rest
      assign ins_val = gt[g] ? (gt[g-1] ? ent_q[g-1] : cmd_value) : ent_q[g];
    end

    if (g == WINDOW_MAX - 1) begin : g_top
      assign pop_val = ent_q[g];
    end else begin : g_mid
      assign pop_val = ent_q[g+1];
    end

    assign ent_d[g] = ins ? ins_val : (pop ? pop_val : ent_q[g]);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (pop) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (ins) begin
      keep_q <= cmd_keep;
      last_q <= cmd_last;
    end
    if (pop) begin
      out_val_q <= ent_q[0];
      out_fin_q <= last_q && (cnt_q == CNT_W'(1));
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.sorted_value = out_val_q;
  assign res_o.final_flag   = out_fin_q;

  assign count_o           = cnt_q;
  assign status_o.idle     = (state_q == ST_IDLE);
  assign status_o.draining = (state_q == ST_DRAIN);

endmodule

### hdl/k_sorted_stream_heap_sorter.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_heap_sorter
// sorts a nearly sorted stream through a window of ascending registers
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// src_i    in   valid/ready   sample_value, end_of_sequence
// res_o    out  valid/ready   sorted_value, final_flag
// cfg_i    in   valid/ready   window_size (ready always high)
//
// an item is inserted while the back end is idle, then the drain state pops results
// until the count is down to its keep count; the back end handles one item at a time
// the command queue registers each sample between its transfer and its insert
// reset clears the window count and sets window_size to 16, no clearing pass
// a two-entry command queue lets samples arrive while the back end drains
// a stalled result holds in the output register while the next pop waits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_sorted_stream_heap_sorter import kss_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kss_in_if.sink    src_i,
  kss_out_if.source res_o,
  kss_cfg_if.sink   cfg_i
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMD_W = CNT_W + VALUE_W + 1;

  logic             fr_valid, fr_ready;
  logic [CMD_W-1:0] fr_data;
  logic             cmd_valid, cmd_ready;
  logic [CMD_W-1:0] cmd_data;
  logic [CNT_W-1:0] heap_cnt;
  kss_status_t      back_sts;

  kss_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_i       (src_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_data_o  (fr_data)
  );

  kss_cmd_fifo #(
    .W (CMD_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_data),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_data_o   (cmd_data)
  );

  kss_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_data_i  (cmd_data),
    .res_o       (res_o),
    .count_o     (heap_cnt),
    .status_o    (back_sts)
  );

  // the store never overflows
  `KSS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, heap_cnt <= CNT_W'(WINDOW_MAX))
  // a command taken while idle adds exactly one entry
  `KSS_ASSERT_NXT(a_insert_grows, clk_i, rst_ni, back_sts.idle && cmd_valid, heap_cnt == $past(heap_cnt) + 1'b1)
  // draining never adds entries
  `KSS_ASSERT_NXT(a_drain_shrinks, clk_i, rst_ni, back_sts.draining, heap_cnt <= $past(heap_cnt))

endmodule
